[rtl/core/npcs_pkg.sv]
// Package for the nearest palette color search unit.
// Holds the request type carried along the cell chain, opcodes and the
// channel distance helper. No dependencies.
package npcs_pkg;

    localparam int DIST_W  = 18;
    localparam int IDX_W   = 8;
    localparam int COLOR_W = 32;
    localparam int COUNT_W = 9;

    // Largest possible distance is 4 * 255 * 255; the all-ones start value
    // lies above it, so the first searched entry always wins.
    localparam logic [DIST_W-1:0] DIST_INIT = '1;
    localparam logic [DIST_W-1:0] DIST_MAX  = 18'd260100;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_MAP   = 1'b1
    } t_op;

    // Request moving down the chain: the input item plus the running best.
    typedef struct packed {
        t_op                op;
        logic [IDX_W-1:0]   entry_index;
        logic [COLOR_W-1:0] color;      // red 31:24, green 23:16, blue 15:8, alpha 7:0
        logic               end_of_run;
        logic [DIST_W-1:0]  min_dist;
        logic [IDX_W-1:0]   best_idx;
    } t_req;

    function automatic logic [15:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] d;
        d = (a >= b) ? (a - b) : (b - a);
        return {8'h00, d} * {8'h00, d};
    endfunction

endpackage

[rtl/core/npcs_if.sv]
// Channel interfaces of the nearest palette color search unit.
// Input request channel and result channel, valid/ready handshake.
// No dependencies.
interface npcs_pix_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] entry_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       end_of_run;

    modport source (output valid, operation, entry_index, red, green, blue, alpha,
                    end_of_run, input ready);
    modport sink   (input valid, operation, entry_index, red, green, blue, alpha,
                    end_of_run, output ready);
endinterface

interface npcs_idx_if;
    logic        valid;
    logic        ready;
    logic [7:0]  color_index;
    logic [17:0] best_distance;
    logic        end_of_run_out;

    modport source (output valid, color_index, best_distance, end_of_run_out, input ready);
    modport sink   (input valid, color_index, best_distance, end_of_run_out, output ready);
endinterface

[rtl/core/npcs_cell.sv]
// One cell of the palette search chain: holds one palette entry, computes
// the distance of a passing pixel and keeps the running best.
// Depends on npcs_pkg.
module npcs_cell #(
    parameter int CELL_INDEX = 0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic [npcs_pkg::COUNT_W-1:0]  i_count,
    input  logic                          i_vld,
    input  npcs_pkg::t_req                i_req,
    output logic                          o_vld,
    output npcs_pkg::t_req                o_req
);

    logic [npcs_pkg::COLOR_W-1:0] r_entry;
    logic                         r_mid_vld;
    npcs_pkg::t_req               r_mid;
    logic [npcs_pkg::DIST_W-1:0]  r_mid_dist;
    logic                         r_out_vld;
    npcs_pkg::t_req               r_out;
    npcs_pkg::t_req               n_out;
    logic [npcs_pkg::DIST_W-1:0]  w_dist;
    logic                         w_active;
    logic                         w_take;

    // Stage A: distance of the incoming pixel to this entry.
    always_comb begin
        w_dist = npcs_pkg::DIST_W'(npcs_pkg::sq_diff(i_req.color[31:24], r_entry[31:24]))
               + npcs_pkg::DIST_W'(npcs_pkg::sq_diff(i_req.color[23:16], r_entry[23:16]))
               + npcs_pkg::DIST_W'(npcs_pkg::sq_diff(i_req.color[15:8],  r_entry[15:8]))
               + npcs_pkg::DIST_W'(npcs_pkg::sq_diff(i_req.color[7:0],   r_entry[7:0]));
    end

    // Stage B: entry zero is always searched, others only below the count.
    always_comb begin
        w_active = (CELL_INDEX == 0) || (npcs_pkg::COUNT_W'(CELL_INDEX) < i_count);
        w_take   = w_active && (r_mid_dist < r_mid.min_dist);
        n_out    = r_mid;
        if (w_take) begin
            n_out.min_dist = r_mid_dist;
            n_out.best_idx = npcs_pkg::IDX_W'(CELL_INDEX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (i_adv) begin
            r_mid_vld <= i_vld;
            r_out_vld <= r_mid_vld;
        end
    end

    // A write lands as its request enters, so requests behind it see the new entry.
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_mid      <= i_req;
            r_mid_dist <= w_dist;
            r_out      <= n_out;
            if (i_vld && (i_req.op == npcs_pkg::OP_WRITE) &&
                (i_req.entry_index == npcs_pkg::IDX_W'(CELL_INDEX))) begin
                r_entry <= i_req.color;
            end
        end
    end

    assign o_vld = r_out_vld;
    assign o_req = r_out;

    a_write_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && i_vld && (i_req.op == npcs_pkg::OP_WRITE) &&
         (i_req.entry_index == npcs_pkg::IDX_W'(CELL_INDEX)))
        |=> (r_entry == $past(i_req.color)))
        else $error("palette entry not updated by write request");

    a_best_not_worse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && r_mid_vld && (r_mid.op == npcs_pkg::OP_MAP) && w_active)
        |=> (r_out.min_dist <= $past(r_mid_dist)))
        else $error("running best exceeds distance of a searched entry");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_out.op == npcs_pkg::OP_MAP))
        |-> (r_out.best_idx <= npcs_pkg::IDX_W'(CELL_INDEX)))
        else $error("best index points past this cell");

endmodule

[rtl/core/nearest_palette_color_search_unit.sv]
// Two register stages per cell between request accept and result.
// Throughput: one request per cycle; the whole chain advances together and
// freezes while a result waits on the output.
// Palette writes travel the chain like pixels, so every pixel sees the palette as of its turn.
// Reset (synchronous, active low) clears all stage valids and sets r_count to 256;
// palette entries have no reset. Write items give no result.
module nearest_palette_color_search_unit #(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    npcs_pix_if.sink                     i_pix,
    npcs_idx_if.source                   o_idx,
    input  logic                         i_cfg_we,
    input  logic [npcs_pkg::COUNT_W-1:0] i_cfg_wdata
);

    logic [npcs_pkg::COUNT_W-1:0] r_count;
    logic                         w_adv;
    logic                         w_vld [PALETTE_DEPTH+1];
    npcs_pkg::t_req               w_req [PALETTE_DEPTH+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 9'd256;
        end else if (i_cfg_we) begin
            r_count <= i_cfg_wdata;
        end
    end

    // Advance unless a result is held at the output.
    assign w_adv       = !o_idx.valid || o_idx.ready;
    assign i_pix.ready = w_adv;

    assign w_vld[0] = i_pix.valid;
    assign w_req[0] = '{op:          npcs_pkg::t_op'(i_pix.operation),
                        entry_index: i_pix.entry_index,
                        color:       {i_pix.red, i_pix.green, i_pix.blue, i_pix.alpha},
                        end_of_run:  i_pix.end_of_run,
                        min_dist:    npcs_pkg::DIST_INIT,
                        best_idx:    '0};

    for (genvar g = 0; g < PALETTE_DEPTH; g++) begin : g_cell
        npcs_cell #(
            .CELL_INDEX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_count (r_count),
            .i_vld   (w_vld[g]),
            .i_req   (w_req[g]),
            .o_vld   (w_vld[g+1]),
            .o_req   (w_req[g+1])
        );
    end

    // Drop write requests at the end of the chain.
    assign o_idx.valid          = w_vld[PALETTE_DEPTH] &&
                                  (w_req[PALETTE_DEPTH].op == npcs_pkg::OP_MAP);
    assign o_idx.color_index    = w_req[PALETTE_DEPTH].best_idx;
    assign o_idx.best_distance  = w_req[PALETTE_DEPTH].min_dist;
    assign o_idx.end_of_run_out = w_req[PALETTE_DEPTH].end_of_run;

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_idx.valid && !o_idx.ready) |-> !i_pix.ready)
        else $error("input accepted while a result is stalled");

    a_dist_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_idx.valid |-> (o_idx.best_distance <= npcs_pkg::DIST_MAX))
        else $error("result distance above the largest possible value");

    a_idx_in_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_idx.valid |-> ({1'b0, o_idx.color_index} < npcs_pkg::COUNT_W'(PALETTE_DEPTH)))
        else $error("result index outside the palette");

endmodule
